[src/frv_pkg.sv]
`default_nettype none

package frv_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 16;
  localparam int CFG_W    = 13;
  // square of a 16-bit magnitude (max 2^30)
  localparam int PROD_W   = 31;

  localparam logic [CFG_W-1:0] HOP_RESET = 13'd512;

  // input word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip_start;
  } frv_in_t;

  // result word
  typedef struct packed {
    logic [VOL_W-1:0] volume;
    logic             last;
  } frv_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_pad;
    logic square;
    logic accum;
    logic div_step;
    logic root_init;
    logic root_step;
    logic load_vol;
  } frv_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clip_start;
    logic done;
    logic out_free;
    logic iter_zero;
  } frv_sts_t;

endpackage

`default_nettype wire

[src/frv_dp.sv]
`default_nettype none

module frv_dp #(
  parameter int MAX_HOP = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire frv_pkg::frv_in_t                in_data,
  input  wire logic                            cfg_we,
  input  wire logic [frv_pkg::CFG_W-1:0]       cfg_data,
  input  wire frv_pkg::frv_cmd_t               cmd,
  output frv_pkg::frv_sts_t                    sts,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output frv_pkg::frv_out_t                    out_data
);
  import frv_pkg::*;

  localparam int CNT_W  = $clog2(MAX_HOP + 1);
  localparam int SUM_W  = PROD_W - 1 + CNT_W;
  localparam int RT_W   = (SUM_W + 1) / 2;
  localparam int OP_W   = 2 * RT_W;
  localparam int ITER_W = $clog2(SUM_W);

  logic [CFG_W-1:0]    hop_r;
  logic [CNT_W-1:0]    count_r;
  logic [SUM_W-1:0]    sum_r;
  logic [15:0]         mag_r;
  logic                done_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SUM_W-1:0]    q_r;
  logic [CNT_W-1:0]    drem_r;
  logic [OP_W-1:0]     op_r;
  logic [RT_W-1:0]     root_r;
  logic [RT_W:0]       rrem_r;
  logic [ITER_W-1:0]   iter_r;
  logic                out_valid_r;
  frv_out_t            out_word_r;

  logic [31:0]         hop_w;
  logic [CNT_W-1:0]    hop_eff;
  logic [15:0]         mag;
  logic [CNT_W:0]      cnt_inc;
  logic                blk_done;
  logic [31:0]         sq_full;
  logic [SUM_W-1:0]    sum_tot;
  logic [CNT_W:0]      dtrial;
  logic                dge;
  logic [CNT_W:0]      ddiff;
  logic [RT_W+2:0]     rtrial;
  logic [RT_W+2:0]     rsub;
  logic                rge;
  logic [RT_W+2:0]     rdiff;

  // effective hop: zero reads as one, clamp at MAX_HOP
  always_comb begin
    if (hop_r == '0) begin
      hop_w = 32'd1;
    end else if (32'(hop_r) > 32'(MAX_HOP)) begin
      hop_w = 32'(MAX_HOP);
    end else begin
      hop_w = 32'(hop_r);
    end
  end
  assign hop_eff = hop_w[CNT_W-1:0];

  // magnitude, 0x8000 maps to 32768
  assign mag = in_data.sample[15] ? (~in_data.sample + 16'd1) : in_data.sample;

  // block fill after this sample
  assign cnt_inc  = in_data.clip_start ? (CNT_W+1)'(1)
                                       : (CNT_W+1)'(count_r) + (CNT_W+1)'(1);
  assign blk_done = cnt_inc >= {1'b0, hop_eff};

  assign sq_full = mag_r * mag_r;
  assign sum_tot = sum_r + SUM_W'(prod_r);

  // restoring divide step, one quotient bit
  assign dtrial = {drem_r, q_r[SUM_W-1]};
  assign dge    = dtrial >= {1'b0, hop_eff};
  assign ddiff  = dtrial - {1'b0, hop_eff};

  // square root step, one root bit
  assign rtrial = {rrem_r, op_r[OP_W-1 -: 2]};
  assign rsub   = {1'b0, root_r, 2'b01};
  assign rge    = rtrial >= rsub;
  assign rdiff  = rtrial - rsub;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hop_r <= HOP_RESET;
    end else if (cfg_we) begin
      hop_r <= cfg_data;
    end
  end

  // accumulator and block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        done_r  <= blk_done;
        count_r <= blk_done ? '0 : cnt_inc[CNT_W-1:0];
        if (in_data.clip_start) begin
          sum_r <= '0;
        end
      end
      if (cmd.accum) begin
        sum_r <= done_r ? '0 : sum_tot;
      end
    end
  end

  // sample and square registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mag_r <= mag;
    end
    if (cmd.square) begin
      prod_r <= sq_full[PROD_W-1:0];
    end
  end

  // iteration counter shared by divider and root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else if (cmd.accum) begin
      iter_r <= ITER_W'(SUM_W - 1);
    end else if (cmd.root_init) begin
      iter_r <= ITER_W'(RT_W - 1);
    end else if ((cmd.div_step || cmd.root_step) && iter_r != '0) begin
      iter_r <= iter_r - ITER_W'(1);
    end
  end

  // divider and root registers
  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      q_r    <= sum_tot;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      q_r    <= {q_r[SUM_W-2:0], dge};
      drem_r <= dge ? ddiff[CNT_W-1:0] : dtrial[CNT_W-1:0];
    end
    if (cmd.root_init) begin
      op_r   <= OP_W'(q_r);
      root_r <= '0;
      rrem_r <= '0;
    end else if (cmd.root_step) begin
      op_r   <= {op_r[OP_W-3:0], 2'b00};
      root_r <= {root_r[RT_W-2:0], rge};
      rrem_r <= rge ? rdiff[RT_W:0] : rtrial[RT_W:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_pad || cmd.load_vol) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pad) begin
      out_word_r.volume <= mag_r;
      out_word_r.last   <= ~done_r;
    end else if (cmd.load_vol) begin
      out_word_r.volume <= root_r[VOL_W-1:0];
      out_word_r.last   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  assign sts.clip_start = in_data.clip_start;
  assign sts.done       = done_r;
  assign sts.out_free   = ~out_valid_r | out_ready;
  assign sts.iter_zero  = (iter_r == '0);

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_pad || cmd.load_vol) |-> (!out_valid_r || out_ready))
    else $error("result loaded over a word not taken");

  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_pad && cmd.load_vol))
    else $error("pad and volume loaded together");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) < 32'(MAX_HOP))
    else $error("block count beyond largest hop");

endmodule

`default_nettype wire

[src/frv_ctrl.sv]
`default_nettype none

module frv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire frv_pkg::frv_sts_t sts,
  output frv_pkg::frv_cmd_t      cmd
);
  import frv_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PAD   = 8'b0000_0010,
    S_SQ    = 8'b0000_0100,
    S_ACC   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_RINIT = 8'b0010_0000,
    S_ROOT  = 8'b0100_0000,
    S_VOL   = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // sequencing of one sample
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.clip_start ? S_PAD : S_SQ;
        end
      end
      S_PAD: begin
        if (sts.out_free) begin
          cmd.load_pad = 1'b1;
          state_nxt    = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = sts.done ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.iter_zero) begin
          state_nxt = S_RINIT;
        end
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.iter_zero) begin
          state_nxt = S_VOL;
        end
      end
      S_VOL: begin
        if (sts.out_free) begin
          cmd.load_vol = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_acc_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && sts.done) |=> (state_r == S_DIV))
    else $error("full block did not start divide");

  a_div_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.iter_zero) |=> (state_r == S_RINIT))
    else $error("divide did not hand over to root");

  a_vol_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_vol |=> (state_r == S_IDLE && in_ready))
    else $error("no return to idle after volume");

endmodule

`default_nettype wire

[src/frame_rms_volume.sv]
// Sequence: a sample that closes no block is squared and accumulated (a clip start sample
//   first emits a pad word); one that closes a block then runs the divide and the root
//   before its volume is shown (one divide step per quotient bit, one root step per
//   root bit, in a single shared sequencer).
// Flow: the next sample is taken only once the last is done; pad and volume wait for output.
// Reset: synchronous active-low rst_n; hop size returns to 512, sum, count and output clear.
`default_nettype none

module frame_rms_volume #(
  parameter int MAX_HOP = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire frv_pkg::frv_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output frv_pkg::frv_out_t              out_data,
  input  wire logic                      cfg_we,
  input  wire logic [frv_pkg::CFG_W-1:0] cfg_data
);
  import frv_pkg::*;

  frv_cmd_t cmd;
  frv_sts_t sts;

  // sequencer
  frv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // accumulate, divide, root, output word
  frv_dp #(
    .MAX_HOP (MAX_HOP)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
